FILE: src/ccw_pkg.sv
// Shared constants, codes and types for the CUBIC congestion window block.
package ccw_pkg;

  // Widths of the item fields and of the internal arithmetic
  localparam int TIME_W     = 48;
  localparam int WIN_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = 64;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MUL_CNT_W  = $clog2(MUL_W);
  localparam int DIV_NUM_W  = 80;
  localparam int DIV_DEN_W  = 48;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);
  localparam int Q_FRAC     = 16;
  localparam int TIME_SHIFT = 10;

  // Integer cube root search: candidate bits from ROOT_TOP down to zero
  localparam int ROOT_TOP = 21;
  localparam int ROOT_W   = ROOT_TOP + 1;
  localparam int ROOT_K_W = $clog2(ROOT_W);

  localparam logic [DIV_DEN_W-1:0] USEC_PER_SEC = DIV_DEN_W'(1000 * 1000);

  // Register reset values
  localparam logic [4:0]  NUM_CONN_RST   = 5'd2;
  localparam logic [15:0] BETA_RST       = 16'd45875;
  localparam logic [15:0] BETA_LM_RST    = 16'd55706;
  localparam logic [31:0] CUBE_FACT_RST  = 32'd1836805;
  localparam logic [15:0] CUBE_SCALE_RST = 16'd410;
  localparam logic [5:0]  CUBE_SHIFT_RST = 6'd40;
  localparam logic [15:0] MSS_RST        = 16'd1460;

  typedef enum logic [1:0] {
    OP_ACK,
    OP_LOSS,
    OP_APP_LIMITED,
    OP_RESET
  } ccw_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CONN,
    CFG_BETA,
    CFG_BETA_LM,
    CFG_CUBE_FACTOR,
    CFG_CUBE_SCALE,
    CFG_CUBE_SHIFT,
    CFG_SEGMENT_SIZE
  } ccw_cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_WAIT,
    S_L_MUL_LM,
    S_L_DIV_BETA,
    S_L_MUL_BETA,
    S_L_DONE,
    S_A_ROOT_INIT,
    S_A_ROOT_SQ,
    S_A_ROOT_CUBE,
    S_A_ROOT_TEST,
    S_A_DT,
    S_A_OFF,
    S_A_CUBE2,
    S_A_SCALE,
    S_A_MSS,
    S_A_TARGET,
    S_A_ALPHA_MUL,
    S_A_ALPHA_DIV,
    S_A_INC_MUL,
    S_A_INC_MUL2,
    S_A_INC_DIV,
    S_A_INC_DONE,
    S_FIN
  } ccw_state_t;

endpackage

FILE: src/ccw_if.sv
// Valid/ready channel interfaces for input events and window results.
interface ccw_in_if;
  import ccw_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [31:0]       bytes_acked;
  logic [31:0]       current_window;
  logic [31:0]       min_delay_us;
  logic [TIME_W-1:0] event_time_us;

  modport source (output valid, op, bytes_acked, current_window, min_delay_us,
                  event_time_us, input ready);
  modport sink (input valid, op, bytes_acked, current_window, min_delay_us,
                event_time_us, output ready);
endinterface

interface ccw_out_if;
  import ccw_pkg::*;
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] new_window;

  modport source (output valid, new_window, input ready);
  modport sink (input valid, new_window, output ready);
endinterface

FILE: src/ccw_mul.sv
// Shared shift-add multiplier: one multiplier bit per cycle, full product.
module ccw_mul
  import ccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_W-1:0]     mcand_r;
  logic [MUL_W-1:0]     hi_r;
  logic [MUL_W-1:0]     lo_r;
  logic [MUL_W:0]       sum;

  // Add the multiplicand when the low bit of the multiplier is set
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        mcand_r <= a;
        hi_r    <= '0;
        lo_r    <= b;
      end else if (busy_r) begin
        // shift the partial product right by one
        hi_r  <= sum[MUL_W:1];
        lo_r  <= {sum[0], lo_r[MUL_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

FILE: src/ccw_div.sv
// Shared restoring divider: one quotient bit per cycle.
module ccw_div
  import ccw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] q_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  // Bring down the next dividend bit and test against the divisor
  assign trial = {rem_r, q_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= num;
      end else if (busy_r) begin
        rem_r <= ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
        q_r   <= {q_r[DIV_NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

FILE: src/cubic_congestion_window.sv
// CUBIC congestion window update: sequencer over a shared multiplier and divider.
//
// Usage: each item on in_ch carries one event (ack, loss, application
// limited, reset) with the acked bytes, current window, minimum delay and
// event time. Exactly one result item per event leaves on out_ch with the
// new window (zero for application limited and reset).
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. An index beyond the register list is ignored.
// All arithmetic runs through one shift-add multiplier and one restoring
// divider, used in turn by the sequencer. Application limited and reset use
// neither unit. The first ack of an epoch with a pending cube root also
// runs the root search (22 root steps, two multiplies each).
// One item is in work at a time: in_ch.ready is high only while idle.
// A finished result sits in the output register; the next item is taken
// even while the receiver stalls, and its result waits until the register
// frees up.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// epoch state and empties the output register.
module cubic_congestion_window
  import ccw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ccw_in_if.sink                in_ch,
  ccw_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ccw_state_t state_r, state_nxt, ret_r, ret_nxt;

  // Configuration registers
  logic [4:0]  num_conn_r;
  logic [15:0] beta_r, beta_lm_r, scale_r, mss_r;
  logic [31:0] cube_fact_r;
  logic [5:0]  shift_r;

  // Epoch state
  logic              epoch_valid_r;
  logic [TIME_W-1:0] epoch_time_r;
  logic [WIN_W-1:0]  last_max_r, acc_r, est_r, origin_r, t0_r;

  // Latched item and scratch
  logic [1:0]          op_r;
  logic [WIN_W-1:0]    acked_r, cwnd_r, delay_r;
  logic [TIME_W-1:0]   ev_r;
  logic [MUL_W-1:0]    x_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_K_W-1:0] k_r;
  logic [39:0]         off_r;
  logic                grow_r;
  logic [WIN_W:0]      target_r;
  logic [15:0]         beff_r;
  logic [WIN_W-1:0]    alpha_r, lm_tmp_r, res_r;
  logic                out_valid_r;
  logic [WIN_W-1:0]    out_win_r;

  // Shared units
  logic                 mul_start, mul_done, div_start, div_done;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [PROD_W-1:0]    mul_prod;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;

  ccw_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  ccw_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Datapath helpers
  logic [4:0]           n_eff;
  logic [9:0]           nn;
  logic [11:0]          three_nn;
  logic [DIV_NUM_W-1:0] beff_lm_num, beff_num;
  logic [ROOT_W-1:0]    cand;
  logic                 cand_ok;
  logic [TIME_W-1:0]    dt;
  logic [39:0]          elapsed, t0_ext;
  logic [MUL_W-1:0]     delta;
  logic [MUL_W:0]       up_sum;
  logic [MUL_W-1:0]     tgt_raw;
  logic [WIN_W:0]       cap, tgt_cap;
  logic [WIN_W:0]       acc_sum, est_sum;
  logic [WIN_W-1:0]     acc_sat, est_new;
  logic [WIN_W:0]       res_max;

  assign n_eff       = (num_conn_r == 5'd0) ? 5'd1 : num_conn_r;
  assign nn          = n_eff * n_eff;
  assign three_nn    = {1'b0, nn, 1'b0} + {2'b0, nn};
  assign beff_lm_num = DIV_NUM_W'({n_eff - 5'd1, 16'b0} + {5'b0, beta_lm_r});
  assign beff_num    = DIV_NUM_W'({n_eff - 5'd1, 16'b0} + {5'b0, beta_r});
  assign cand        = root_r | (ROOT_W'(1) << k_r);
  assign cand_ok     = (mul_prod[PROD_W-1:MUL_W] == '0) && (mul_prod[MUL_W-1:0] <= x_r);
  assign dt          = ev_r + {16'b0, delay_r} - epoch_time_r;
  assign elapsed     = div_quo[39:0];
  assign t0_ext      = {8'b0, t0_r};

  // Cubic target, saturating both ways, then capped
  assign delta   = mul_prod[MUL_W-1:0] >> shift_r;
  assign up_sum  = {1'b0, delta} + {33'b0, origin_r};
  assign tgt_raw = grow_r ? (up_sum[MUL_W] ? '1 : up_sum[MUL_W-1:0])
                          : ((MUL_W'(origin_r) >= delta) ? MUL_W'(origin_r) - delta : '0);
  assign cap     = {1'b0, cwnd_r} + {2'b0, acc_r[WIN_W-1:1]};
  assign tgt_cap = (tgt_raw > MUL_W'(cap)) ? cap : tgt_raw[WIN_W:0];

  assign acc_sum = {1'b0, acc_r} + {1'b0, acked_r};
  assign acc_sat = acc_sum[WIN_W] ? '1 : acc_sum[WIN_W-1:0];
  assign est_sum = {1'b0, est_r} + {1'b0, div_quo[WIN_W-1:0]};
  assign est_new = ((|div_quo[DIV_NUM_W-1:WIN_W]) || est_sum[WIN_W]) ? '1
                                                                       : est_sum[WIN_W-1:0];
  assign res_max = (target_r > {1'b0, est_new}) ? target_r : {1'b0, est_new};

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Next state and unit requests
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (ccw_op_t'(op_r))
          OP_ACK: begin
            if (!epoch_valid_r && (last_max_r > cwnd_r)) begin
              mul_start = 1'b1;
              mul_a     = MUL_W'(cube_fact_r);
              mul_b     = MUL_W'(last_max_r - cwnd_r);
              ret_nxt   = S_A_ROOT_INIT;
              state_nxt = S_WAIT;
            end else begin
              state_nxt = S_A_DT;
            end
          end
          OP_LOSS: begin
            div_start = 1'b1;
            div_num   = beff_lm_num;
            div_den   = DIV_DEN_W'(n_eff);
            ret_nxt   = S_L_MUL_LM;
            state_nxt = S_WAIT;
          end
          OP_APP_LIMITED, OP_RESET: state_nxt = S_FIN;
          default: state_nxt = S_FIN;
        endcase
      end
      S_WAIT: begin
        if (mul_done || div_done) state_nxt = ret_r;
      end
      S_L_MUL_LM: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(cwnd_r);
        mul_b     = MUL_W'(div_quo[15:0]);
        ret_nxt   = S_L_DIV_BETA;
        state_nxt = S_WAIT;
      end
      S_L_DIV_BETA: begin
        div_start = 1'b1;
        div_num   = beff_num;
        div_den   = DIV_DEN_W'(n_eff);
        ret_nxt   = S_L_MUL_BETA;
        state_nxt = S_WAIT;
      end
      S_L_MUL_BETA: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(cwnd_r);
        mul_b     = MUL_W'(div_quo[15:0]);
        ret_nxt   = S_L_DONE;
        state_nxt = S_WAIT;
      end
      S_L_DONE: state_nxt = S_FIN;
      S_A_ROOT_INIT: state_nxt = S_A_ROOT_SQ;
      S_A_ROOT_SQ: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(cand);
        mul_b     = MUL_W'(cand);
        ret_nxt   = S_A_ROOT_CUBE;
        state_nxt = S_WAIT;
      end
      S_A_ROOT_CUBE: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[MUL_W-1:0];
        mul_b     = MUL_W'(cand);
        ret_nxt   = S_A_ROOT_TEST;
        state_nxt = S_WAIT;
      end
      S_A_ROOT_TEST: begin
        state_nxt = (k_r == '0) ? S_A_DT : S_A_ROOT_SQ;
      end
      S_A_DT: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({dt, TIME_SHIFT'(0)});
        div_den   = USEC_PER_SEC;
        ret_nxt   = S_A_OFF;
        state_nxt = S_WAIT;
      end
      S_A_OFF: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'((elapsed > t0_ext) ? elapsed - t0_ext : t0_ext - elapsed);
        mul_b     = MUL_W'((elapsed > t0_ext) ? elapsed - t0_ext : t0_ext - elapsed);
        ret_nxt   = S_A_CUBE2;
        state_nxt = S_WAIT;
      end
      S_A_CUBE2: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[MUL_W-1:0];
        mul_b     = MUL_W'(off_r);
        ret_nxt   = S_A_SCALE;
        state_nxt = S_WAIT;
      end
      S_A_SCALE: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[MUL_W-1:0];
        mul_b     = MUL_W'(scale_r);
        ret_nxt   = S_A_MSS;
        state_nxt = S_WAIT;
      end
      S_A_MSS: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[MUL_W-1:0];
        mul_b     = MUL_W'(mss_r);
        ret_nxt   = S_A_TARGET;
        state_nxt = S_WAIT;
      end
      S_A_TARGET: begin
        if (est_r != '0) begin
          div_start = 1'b1;
          div_num   = beff_num;
          div_den   = DIV_DEN_W'(n_eff);
          ret_nxt   = S_A_ALPHA_MUL;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_A_ALPHA_MUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(three_nn);
        mul_b     = MUL_W'({1'b1, 16'b0} - {1'b0, div_quo[15:0]});
        ret_nxt   = S_A_ALPHA_DIV;
        state_nxt = S_WAIT;
      end
      S_A_ALPHA_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({mul_prod[MUL_W-1-Q_FRAC:0], Q_FRAC'(0)});
        div_den   = DIV_DEN_W'({1'b1, 16'b0} + {1'b0, beff_r});
        ret_nxt   = S_A_INC_MUL;
        state_nxt = S_WAIT;
      end
      S_A_INC_MUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(acc_r);
        mul_b     = MUL_W'(mss_r);
        ret_nxt   = S_A_INC_MUL2;
        state_nxt = S_WAIT;
      end
      S_A_INC_MUL2: begin
        mul_start = 1'b1;
        mul_a     = mul_prod[MUL_W-1:0];
        mul_b     = MUL_W'(alpha_r);
        ret_nxt   = S_A_INC_DIV;
        state_nxt = S_WAIT;
      end
      S_A_INC_DIV: begin
        div_start = 1'b1;
        div_num   = mul_prod[DIV_NUM_W-1:0];
        div_den   = DIV_DEN_W'({est_r, Q_FRAC'(0)});
        ret_nxt   = S_A_INC_DONE;
        state_nxt = S_WAIT;
      end
      S_A_INC_DONE: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_conn_r  <= NUM_CONN_RST;
      beta_r      <= BETA_RST;
      beta_lm_r   <= BETA_LM_RST;
      cube_fact_r <= CUBE_FACT_RST;
      scale_r     <= CUBE_SCALE_RST;
      shift_r     <= CUBE_SHIFT_RST;
      mss_r       <= MSS_RST;
    end else if (cfg_we) begin
      unique case (ccw_cfg_idx_t'(cfg_index))
        CFG_NUM_CONN:     num_conn_r  <= cfg_data[4:0];
        CFG_BETA:         beta_r      <= cfg_data[15:0];
        CFG_BETA_LM:      beta_lm_r   <= cfg_data[15:0];
        CFG_CUBE_FACTOR:  cube_fact_r <= cfg_data[31:0];
        CFG_CUBE_SCALE:   scale_r     <= cfg_data[15:0];
        CFG_CUBE_SHIFT:   shift_r     <= cfg_data[5:0];
        CFG_SEGMENT_SIZE: mss_r       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Epoch state and scratch registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_valid_r <= 1'b0;
      epoch_time_r  <= '0;
      last_max_r    <= '0;
      acc_r         <= '0;
      est_r         <= '0;
      origin_r      <= '0;
      t0_r          <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          // latch the item
          if (in_ch.valid) begin
            op_r    <= in_ch.op;
            acked_r <= in_ch.bytes_acked;
            cwnd_r  <= in_ch.current_window;
            delay_r <= in_ch.min_delay_us;
            ev_r    <= in_ch.event_time_us;
          end
        end
        S_DISPATCH: begin
          res_r <= '0;
          unique case (ccw_op_t'(op_r))
            OP_ACK: begin
              if (!epoch_valid_r) begin
                epoch_valid_r <= 1'b1;
                epoch_time_r  <= ev_r;
                acc_r         <= acked_r;
                est_r         <= cwnd_r;
                if (last_max_r <= cwnd_r) begin
                  t0_r     <= '0;
                  origin_r <= cwnd_r;
                end else begin
                  origin_r <= last_max_r;
                end
              end else begin
                acc_r <= acc_sat;
              end
            end
            OP_LOSS: ;
            OP_APP_LIMITED: epoch_valid_r <= 1'b0;
            OP_RESET: begin
              epoch_valid_r <= 1'b0;
              epoch_time_r  <= '0;
              last_max_r    <= '0;
              acc_r         <= '0;
              est_r         <= '0;
              origin_r      <= '0;
              t0_r          <= '0;
            end
            default: ;
          endcase
        end
        S_L_DIV_BETA: lm_tmp_r <= mul_prod[WIN_W+Q_FRAC-1:Q_FRAC];
        S_L_DONE: begin
          res_r <= mul_prod[WIN_W+Q_FRAC-1:Q_FRAC];
          if (({1'b0, cwnd_r} + {17'b0, mss_r}) < {1'b0, last_max_r}) begin
            last_max_r <= lm_tmp_r;
          end else begin
            last_max_r <= cwnd_r;
          end
          epoch_valid_r <= 1'b0;
        end
        S_A_ROOT_INIT: begin
          x_r    <= mul_prod[MUL_W-1:0];
          root_r <= '0;
          k_r    <= ROOT_K_W'(ROOT_TOP);
        end
        S_A_ROOT_TEST: begin
          // keep the candidate bit when its cube fits
          if (cand_ok) root_r <= cand;
          k_r <= k_r - 1'b1;
          if (k_r == '0) t0_r <= WIN_W'(cand_ok ? cand : root_r);
        end
        S_A_OFF: begin
          grow_r <= elapsed > t0_ext;
          off_r  <= (elapsed > t0_ext) ? elapsed - t0_ext : t0_ext - elapsed;
        end
        S_A_TARGET: begin
          target_r <= tgt_cap;
          if (est_r == '0) begin
            acc_r <= '0;
            res_r <= tgt_cap[WIN_W] ? '1 : tgt_cap[WIN_W-1:0];
          end
        end
        S_A_ALPHA_MUL: beff_r  <= div_quo[15:0];
        S_A_INC_MUL:   alpha_r <= div_quo[WIN_W-1:0];
        S_A_INC_DONE: begin
          est_r <= est_new;
          acc_r <= '0;
          res_r <= res_max[WIN_W] ? '1 : res_max[WIN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_win_r   <= res_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.new_window = out_win_r;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the CUBIC congestion window block.
module testbench;
  import ccw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic [63:0] M32 = 64'hFFFF_FFFF;
  localparam logic [63:0] TIME_MASK = (64'd1 << TIME_W) - 1;

  typedef struct {
    ccw_op_t     op;
    logic [31:0] acked;
    logic [31:0] cwnd;
    logic [31:0] delay;
    logic [47:0] ev;
    bit          drain;
  } event_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccw_in_if  in_ch();
  ccw_out_if out_ch();

  cubic_congestion_window i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  event_item_t pending_items[$];
  logic [31:0] window_q[$];
  event_item_t cur_item;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned hold_left;
  logic        hold_go;
  logic [63:0] now_us;

  // Register copies
  logic [4:0]  n_conn;
  logic [15:0] beta;
  logic [15:0] beta_lm;
  logic [31:0] cube_fact;
  logic [15:0] cube_scale;
  logic [5:0]  cube_sh;
  logic [15:0] mss;

  // Epoch state copies
  bit          ep_valid;
  logic [47:0] ep_time;
  logic [31:0] last_max;
  logic [31:0] acc_bytes;
  logic [31:0] reno_est;
  logic [31:0] origin_win;
  logic [31:0] t_origin;

  function automatic void clear_window_state();
    ep_valid = 0;
    ep_time = '0;
    last_max = '0;
    acc_bytes = '0;
    reno_est = '0;
    origin_win = '0;
    t_origin = '0;
  endfunction

  function automatic logic [63:0] conn_count();
    return (n_conn == 0) ? 64'd1 : 64'(n_conn);
  endfunction

  function automatic logic [63:0] eff_factor(logic [15:0] f);
    logic [63:0] n;
    n = conn_count();
    return (((n - 1) << 16) + 64'(f)) / n;
  endfunction

  function automatic logic [63:0] alpha_q16();
    logic [63:0] n;
    logic [63:0] b;
    n = conn_count();
    b = eff_factor(beta);
    return ((64'd3 * n * n * (64'd65536 - b)) << 16) / (64'd65536 + b);
  endfunction

  function automatic logic [31:0] cube_root(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int k = ROOT_TOP; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (c * c <= x / c) r = c;
    end
    return r[31:0];
  endfunction

  // floor(a*b/d), saturating when the quotient leaves 64 bits
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] d);
    logic [127:0] q;
    q = (128'(a) * 128'(b)) / 128'(d);
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > M32) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] ack_window(event_item_t it);
    logic [63:0] dt, elapsed, off, delta, target, cap, inc;
    if (!ep_valid) begin
      ep_valid = 1;
      ep_time = it.ev;
      acc_bytes = it.acked;
      reno_est = it.cwnd;
      if (last_max <= it.cwnd) begin
        t_origin = '0;
        origin_win = it.cwnd;
      end else begin
        t_origin = cube_root(64'(cube_fact) * 64'(last_max - it.cwnd));
        origin_win = last_max;
      end
    end else begin
      acc_bytes = sat32(64'(acc_bytes) + 64'(it.acked));
    end
    dt = (64'(it.ev) + 64'(it.delay) - 64'(ep_time)) & TIME_MASK;
    elapsed = (dt / 64'd1000000) * 64'd1024 + ((dt % 64'd1000000) * 64'd1024) / 64'd1000000;
    off = (64'(t_origin) > elapsed) ? 64'(t_origin) - elapsed : elapsed - 64'(t_origin);
    delta = 64'(cube_scale) * off;
    delta = delta * off;
    delta = delta * off;
    delta = delta * 64'(mss);
    delta = delta >> cube_sh;
    // Clamp the cubic target at both ends
    if (elapsed > 64'(t_origin))
      target = (delta > ~64'd0 - 64'(origin_win)) ? ~64'd0 : 64'(origin_win) + delta;
    else
      target = (64'(origin_win) >= delta) ? 64'(origin_win) - delta : 64'd0;
    cap = 64'(it.cwnd) + 64'(acc_bytes / 2);
    if (target > cap) target = cap;
    // Reno estimate grows only when nonzero
    if (reno_est != 0) begin
      inc = scaled_quotient(64'(acc_bytes) * 64'(mss), alpha_q16(), 64'(reno_est) << 16);
      reno_est = sat32((inc > M32) ? ~64'd0 : 64'(reno_est) + inc);
    end
    acc_bytes = '0;
    return sat32((target > 64'(reno_est)) ? target : 64'(reno_est));
  endfunction

  function automatic logic [31:0] predict_window(event_item_t it);
    logic [63:0] prod;
    case (it.op)
      OP_ACK: return ack_window(it);
      OP_LOSS: begin
        if (64'(it.cwnd) + 64'(mss) < 64'(last_max)) begin
          prod = (64'(it.cwnd) * eff_factor(beta_lm)) >> 16;
          last_max = prod[31:0];
        end else begin
          last_max = it.cwnd;
        end
        ep_valid = 0;
        prod = (64'(it.cwnd) * eff_factor(beta)) >> 16;
        return prod[31:0];
      end
      OP_APP_LIMITED: begin
        ep_valid = 0;
        return '0;
      end
      default: begin
        clear_window_state();
        return '0;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // Clock and cycle limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cubic_congestion_window verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Driver: offer pending items, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) window_q.push_back(predict_window(cur_item));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 &&
            !(pending_items[0].drain && (window_q.size() != 0 || in_ch.valid)) &&
            $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= cur_item.op;
          in_ch.bytes_acked <= cur_item.acked;
          in_ch.current_window <= cur_item.cwnd;
          in_ch.min_delay_us <= cur_item.delay;
          in_ch.event_time_us <= cur_item.ev;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (window_q.size() == 0) report_mismatch("unexpected item", out_ch.new_window, 0);
        else if (out_ch.new_window !== window_q[0])
          report_mismatch("new_window", out_ch.new_window, window_q.pop_front());
        else void'(window_q.pop_front());
      end
      out_ch.ready <= (hold_left == 0) && !hold_go && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(65535)), 32'($urandom)};
  endfunction

  function automatic void add_item(ccw_op_t op, logic [31:0] acked, logic [31:0] cwnd,
                                   logic [31:0] delay, logic [47:0] ev, bit drain = 0);
    event_item_t it;
    it.op = op;
    it.acked = acked;
    it.cwnd = cwnd;
    it.delay = delay;
    it.ev = ev;
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NUM_CONN:     n_conn = v[4:0];
      CFG_BETA:         beta = v[15:0];
      CFG_BETA_LM:      beta_lm = v[15:0];
      CFG_CUBE_FACTOR:  cube_fact = v;
      CFG_CUBE_SCALE:   cube_scale = v[15:0];
      CFG_CUBE_SHIFT:   cube_sh = v[5:0];
      CFG_SEGMENT_SIZE: mss = v[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || window_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly loss-then-ack epochs with random content, some noise
  task automatic add_random(int unsigned count);
    int unsigned added;
    int unsigned r;
    logic [31:0] w;
    logic [31:0] cw;
    added = 0;
    while (added < count) begin
      r = $urandom_range(99);
      if (r < 8) begin
        add_item(ccw_op_t'($urandom_range(3)), $urandom, $urandom, $urandom, rand48());
        added++;
      end else if (r < 15) begin
        add_item(OP_ACK, $urandom, $urandom, $urandom, rand48());
        added++;
      end else begin
        w = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2_000_000, 1000);
        cw = w;
        add_item(OP_LOSS, $urandom, w, $urandom_range(200000), now_us[47:0]);
        added++;
        cw = w - w / ($urandom_range(6) + 2);
        for (int k = $urandom_range(8, 1); k > 0; k--) begin
          now_us = now_us + (($urandom_range(9) == 0) ? $urandom_range(30_000_000)
                                                       : $urandom_range(200_000));
          cw = cw + $urandom_range(4 * mss);
          add_item(OP_ACK, mss * $urandom_range(10), cw, $urandom_range(200_000, 100),
                   now_us[47:0]);
          added++;
        end
        if ($urandom_range(9) == 0) begin
          add_item(OP_APP_LIMITED, $urandom, cw, $urandom, now_us[47:0]);
          added++;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ACK;
    in_ch.bytes_acked = '0;
    in_ch.current_window = '0;
    in_ch.min_delay_us = '0;
    in_ch.event_time_us = '0;
    out_ch.ready = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    cycle_count = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    now_us = 64'd1000;
    n_conn = NUM_CONN_RST;
    beta = BETA_RST;
    beta_lm = BETA_LM_RST;
    cube_fact = CUBE_FACT_RST;
    cube_scale = CUBE_SCALE_RST;
    cube_sh = CUBE_SHIFT_RST;
    mss = MSS_RST;
    clear_window_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every op, field extremes, root and saturation paths
    add_item(OP_ACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_item(OP_ACK, 32'hFFFF_FFFF, 32'd0, 32'd0, 48'd0);
    add_item(OP_APP_LIMITED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_item(OP_ACK, 32'd1460, 32'd0, 32'd100, 48'd5);
    add_item(OP_ACK, 32'd1460, 32'd0, 32'd100, 48'd7);
    add_item(OP_LOSS, 32'd0, 32'hFFFF_FFFF, 32'd0, 48'd10);
    add_item(OP_ACK, 32'd1460, 32'd100000, 32'd20000, 48'd20);
    add_item(OP_ACK, 32'd2920, 32'd101460, 32'd20000, 48'd2_000_000);
    add_item(OP_ACK, 32'hFFFF_FFFF, 32'd102920, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_item(OP_LOSS, 32'd0, 32'd200000, 32'd0, 48'd100);
    add_item(OP_LOSS, 32'd0, 32'd100000, 32'd0, 48'd200);
    add_item(OP_ACK, 32'd1460, 32'd60000, 32'd1, 48'd300);
    add_item(OP_ACK, 32'd1460, 32'd61460, 32'd1, 48'd300000000);
    add_item(OP_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    add_item(OP_ACK, 32'd0, 32'd5000, 32'd0, 48'd0);
    add_item(OP_LOSS, 32'd0, 32'd0, 32'd0, 48'd0);
    add_item(OP_RESET, 32'd0, 32'd0, 32'd0, 48'd0);
    wait_idle();

    // Phases: register settings crossed with idling patterns
    for (int p = 0; p < 8; p++) begin
      case (p)
        1: begin
          write_reg(CFG_NUM_CONN, 32'd1);
          write_reg(CFG_BETA, 32'd0);
          write_reg(CFG_BETA_LM, 32'd65535);
          write_reg(CFG_CUBE_FACTOR, 32'hFFFF_FFFF);
          write_reg(CFG_CUBE_SCALE, 32'd65535);
          write_reg(CFG_CUBE_SHIFT, 32'd0);
          write_reg(CFG_SEGMENT_SIZE, 32'd65535);
        end
        2: begin
          write_reg(CFG_NUM_CONN, 32'd16);
          write_reg(CFG_BETA, 32'd65535);
          write_reg(CFG_BETA_LM, 32'd0);
          write_reg(CFG_CUBE_FACTOR, 32'd0);
          write_reg(CFG_CUBE_SCALE, 32'd0);
          write_reg(CFG_CUBE_SHIFT, 32'd63);
          write_reg(CFG_SEGMENT_SIZE, 32'd1);
          write_reg(CFG_UNUSED, $urandom);
        end
        3: begin
          write_reg(CFG_NUM_CONN, 32'd0);
          write_reg(CFG_CUBE_FACTOR, CUBE_FACT_RST);
          write_reg(CFG_CUBE_SCALE, CUBE_SCALE_RST);
          write_reg(CFG_CUBE_SHIFT, CUBE_SHIFT_RST);
          write_reg(CFG_SEGMENT_SIZE, MSS_RST);
        end
        4: write_reg(CFG_NUM_CONN, 32'd31);
        5, 6, 7: begin
          write_reg(CFG_NUM_CONN, $urandom_range(31));
          write_reg(CFG_BETA, $urandom_range(65535));
          write_reg(CFG_BETA_LM, $urandom_range(65535));
          write_reg(CFG_CUBE_FACTOR, $urandom);
          write_reg(CFG_CUBE_SCALE, $urandom_range(65535));
          write_reg(CFG_CUBE_SHIFT, $urandom_range(63));
          write_reg(CFG_SEGMENT_SIZE, $urandom_range(65535, 1));
        end
        default: ;
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      // Hold the receiver off while the sender keeps offering items
      if (p == 2) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      add_random(125);
      // Pause the sender until all results are back
      add_item(OP_LOSS, $urandom, $urandom, $urandom, rand48(), 1);
      add_random(125);
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && window_q.size() == 0)
      $display("cubic_congestion_window verification clean");
    else
      $display("cubic_congestion_window verification failed");
    $finish;
  end

endmodule
